// File: src/msls_pkg.sv
`default_nettype none
package msls_pkg;

  // Controller states: one per datapath step
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASS,
    ST_FC,
    ST_TS,
    ST_AV,
    ST_TOL1,
    ST_FRAC,
    ST_MF,
    ST_CHECK,
    ST_TOL2,
    ST_DZ,
    ST_DT,
    ST_OUT
  } state_e;

  // Operations of the shared multiply/divide unit
  typedef enum logic [3:0] {
    OP_NONE,
    OP_FC,
    OP_TS,
    OP_AV,
    OP_TOL1,
    OP_FRAC,
    OP_MF,
    OP_TOL2,
    OP_DZ,
    OP_DT
  } op_e;

  typedef struct packed {
    logic load;
    logic go;
    logic cap;
    logic cls;
    logic pass;
    logic emit;
    op_e  sel;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic case_a;
    logic dw_neg;
    logic case_c;
    logic approx;
    logic dm_zero;
  } stat_t;

  // Configuration register indexes
  localparam logic REG_TIME_STEP = 1'b0;
  localparam logic REG_EQUAL_TOL = 1'b1;

  localparam logic signed [63:0] S_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S_MIN = {1'b1, 63'd0};

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? S_MIN : S_MAX;
    end else begin
      sat_add = s[63:0];
    end
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      sat_sub = s[64] ? S_MIN : S_MAX;
    end else begin
      sat_sub = s[63:0];
    end
  endfunction

  function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
    sat_neg = (a == S_MIN) ? S_MAX : -a;
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    mag = a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m);
    if (neg) begin
      from_mag = m[63] ? S_MIN : -$signed(m);
    end else begin
      from_mag = m[63] ? S_MAX : $signed(m);
    end
  endfunction

endpackage
`default_nettype wire

// File: src/msls_mdu.sv
`default_nettype none
module msls_mdu #(
  parameter int FRACTION_BITS = 48
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         go_i,
  input  wire logic         div_i,
  input  wire logic [63:0]  a_i,
  input  wire logic [63:0]  b_i,
  output logic [127:0]      prod_o,
  output logic [63:0]       quo_o,
  output logic              busy_o,
  output logic              done_o
);

  logic [127:0] acc_q, acc_d;
  logic [63:0]  a_q, a_d, b_q, b_d;
  logic [5:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d, done_q, done_d, mode_div_q, mode_div_d, sat_q, sat_d;
  logic [127:0] num_w, sh_w;
  logic [63:0]  dsr_w, hi_w;
  logic [64:0]  sum_w;
  logic         ge_w;

  // One shift-add or one restoring divide step a cycle
  always_comb begin
    num_w = {64'd0, a_i} << FRACTION_BITS;
    dsr_w = (b_i == 64'd0) ? 64'd1 : b_i;
    sum_w = {1'b0, acc_q[127:64]} + {1'b0, (b_q[0] ? a_q : 64'd0)};
    sh_w  = {acc_q[126:0], 1'b0};
    ge_w  = acc_q[127] || (sh_w[127:64] >= a_q);
    hi_w  = ge_w ? (sh_w[127:64] - a_q) : sh_w[127:64];

    acc_d      = acc_q;
    a_d        = a_q;
    b_d        = b_q;
    cnt_d      = cnt_q;
    busy_d     = busy_q;
    done_d     = 1'b0;
    mode_div_d = mode_div_q;
    sat_d      = sat_q;

    if (go_i) begin
      busy_d     = 1'b1;
      cnt_d      = '0;
      mode_div_d = div_i;
      if (div_i) begin
        a_d   = dsr_w;
        b_d   = '0;
        acc_d = num_w;
        sat_d = num_w[127:64] >= dsr_w;
      end else begin
        a_d   = a_i;
        b_d   = b_i;
        acc_d = '0;
        sat_d = 1'b0;
      end
    end else if (busy_q) begin
      if (mode_div_q) begin
        acc_d = {hi_w, sh_w[63:0]};
        b_d   = {b_q[62:0], ge_w};
      end else begin
        acc_d = {sum_w, acc_q[63:1]};
        b_d   = {1'b0, b_q[63:1]};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      done_q     <= 1'b0;
      cnt_q      <= '0;
      mode_div_q <= 1'b0;
      sat_q      <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      done_q     <= done_d;
      cnt_q      <= cnt_d;
      mode_div_q <= mode_div_d;
      sat_q      <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign prod_o = acc_q;
  assign quo_o  = sat_q ? '1 : b_q;
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// File: src/msls_dp.sv
`default_nettype none
module msls_dp #(
  parameter int FRACTION_BITS = 48
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire msls_pkg::cmd_t     cmd_i,
  output msls_pkg::stat_t         stat_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [62:0]        cfg_data_i,
  input  wire logic               first_layer_i,
  input  wire logic signed [63:0] surface_flux_i,
  input  wire logic [62:0]        layer_thickness_i,
  input  wire logic signed [63:0] pore_flux_top_i,
  input  wire logic signed [63:0] pore_flux_bottom_i,
  input  wire logic [62:0]        concentration_i,
  input  wire logic [62:0]        matrix_matter_i,
  input  wire logic signed [63:0] matrix_sink_in_i,
  output logic signed [63:0]      pore_sink_o,
  output logic signed [63:0]      matrix_sink_out_o,
  output logic signed [63:0]      flux_below_o
);
  import msls_pkg::*;

  localparam logic [63:0] OneQ = 64'd1 << FRACTION_BITS;
  localparam logic [63:0] MarginRaw =
    (OneQ + 64'd5000000000000000) / 64'd10000000000000000;
  localparam logic [63:0] Margin = (MarginRaw == 64'd0) ? 64'd1 : MarginRaw;

  logic [62:0]        ts_q;
  logic [48:0]        tol_q;
  logic signed [63:0] carried_q;
  logic [62:0]        dz_q, conc_q, matter_q;
  logic signed [63:0] sink_in_q, flux_in_q, water_in_q, water_out_q, dwater_q;
  logic signed [63:0] matter_in_q, fc_q, av_q, dmatter_q, x_q, y_q, fb_q, ps_q;
  logic [63:0]        frac_q;
  logic signed [63:0] ps_out_q, sink_out_q, fb_out_q;

  logic signed [63:0] flux_in_w, water_in_w, water_out_w, nb_w;
  logic signed [63:0] mulq_w, divq_w, t_w, m_w, cmp_a_w, cmp_b_w;
  logic [63:0]        op_a_w, op_b_w, diff_w, quo_w, mq_mag_w;
  logic [127:0]       prod_w, psh_w, dsh_w;
  logic               op_div_w, neg_w, approx_w, busy_w, done_w;

  msls_mdu #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.go),
    .div_i  (op_div_w),
    .a_i    (op_a_w),
    .b_i    (op_b_w),
    .prod_o (prod_w),
    .quo_o  (quo_w),
    .busy_o (busy_w),
    .done_o (done_w)
  );

  // Pick operands and result sign for the current step
  always_comb begin
    nb_w     = sat_neg(dmatter_q);
    op_a_w   = '0;
    op_b_w   = '0;
    op_div_w = 1'b0;
    neg_w    = 1'b0;
    cmp_a_w  = matter_in_q;
    cmp_b_w  = nb_w;
    case (cmd_i.sel)
      OP_FC: begin
        op_a_w = {1'b0, conc_q};
        op_b_w = mag(dwater_q);
      end
      OP_TS: begin
        op_a_w = mag(sink_in_q);
        op_b_w = {1'b0, ts_q};
        neg_w  = sink_in_q[63];
      end
      OP_AV: begin
        op_a_w = mag(av_q);
        op_b_w = {1'b0, dz_q};
        neg_w  = av_q[63];
      end
      OP_TOL1: begin
        op_a_w  = {15'd0, tol_q};
        op_b_w  = mag(water_in_q);
        cmp_a_w = dwater_q;
        cmp_b_w = water_in_q;
      end
      OP_FRAC: begin
        op_a_w   = mag(dwater_q);
        op_b_w   = water_in_q;
        op_div_w = 1'b1;
        neg_w    = dwater_q[63];
      end
      OP_MF: begin
        op_a_w = mag(matter_in_q);
        op_b_w = frac_q;
        neg_w  = matter_in_q[63];
      end
      OP_TOL2: begin
        op_a_w = {15'd0, tol_q};
        op_b_w = mag(nb_w);
      end
      OP_DZ: begin
        op_a_w   = mag(x_q);
        op_b_w   = {1'b0, dz_q};
        op_div_w = 1'b1;
        neg_w    = x_q[63];
      end
      OP_DT: begin
        op_a_w   = mag(y_q);
        op_b_w   = {1'b0, ts_q};
        op_div_w = 1'b1;
        neg_w    = y_q[63];
      end
      default: begin
        op_a_w = '0;
      end
    endcase
  end

  // Scale products and quotients, and test approximate equality
  always_comb begin
    psh_w    = prod_w >> FRACTION_BITS;
    mq_mag_w = (|psh_w[127:64]) ? '1 : psh_w[63:0];
    mulq_w   = from_mag(neg_w, mq_mag_w);
    divq_w   = from_mag(neg_w, quo_w);
    diff_w   = (cmp_a_w >= cmp_b_w) ? 64'(cmp_a_w - cmp_b_w) : 64'(cmp_b_w - cmp_a_w);
    dsh_w    = {64'd0, diff_w} << FRACTION_BITS;
    approx_w = (cmp_b_w == 64'sd0) ? (cmp_a_w == 64'sd0) : (dsh_w < prod_w);
    t_w      = sat_sub(mulq_w, $signed(Margin));
    m_w      = (fc_q < t_w) ? fc_q : t_w;
  end

  // Load-time flux selection and saturating negations
  always_comb begin
    flux_in_w   = first_layer_i ? surface_flux_i : carried_q;
    water_in_w  = sat_neg(pore_flux_top_i);
    water_out_w = sat_neg(pore_flux_bottom_i);
  end

  // Configuration and carried flux
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q      <= 63'd281474976710656;
      tol_q     <= 49'd28147497671;
      carried_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_TIME_STEP: ts_q  <= cfg_data_i;
          REG_EQUAL_TOL: tol_q <= cfg_data_i[48:0];
        endcase
      end
      if (cmd_i.emit) begin
        carried_q <= fb_q;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dz_q        <= layer_thickness_i;
      conc_q      <= concentration_i;
      matter_q    <= matrix_matter_i;
      sink_in_q   <= matrix_sink_in_i;
      flux_in_q   <= flux_in_w;
      water_in_q  <= water_in_w;
      water_out_q <= water_out_w;
      dwater_q    <= sat_sub(water_in_w, water_out_w);
      matter_in_q <= sat_neg(flux_in_w);
    end
    if (cmd_i.cls) begin
      dmatter_q <= (water_out_q <= 64'sd0) ? sat_neg(matter_in_q) : 64'sd0;
    end
    if (cmd_i.pass) begin
      fb_q <= flux_in_q;
      ps_q <= '0;
    end
    if (cmd_i.cap) begin
      case (cmd_i.sel)
        OP_FC: fc_q <= mulq_w;
        OP_TS: av_q <= sat_add($signed({1'b0, matter_q}), mulq_w);
        OP_AV: dmatter_q <= m_w[63] ? 64'sd0 : m_w;
        OP_TOL1: begin
          if (approx_w) begin
            frac_q <= OneQ;
          end
        end
        OP_FRAC: begin
          if (divq_w[63]) begin
            frac_q <= '0;
          end else if (divq_w > $signed(OneQ)) begin
            frac_q <= OneQ;
          end else begin
            frac_q <= divq_w;
          end
        end
        OP_MF: dmatter_q <= sat_neg(mulq_w);
        OP_TOL2: begin
          x_q  <= approx_w ? matter_in_q : nb_w;
          fb_q <= approx_w ? 64'sd0 : sat_neg(sat_add(matter_in_q, dmatter_q));
        end
        OP_DZ: y_q  <= divq_w;
        OP_DT: ps_q <= divq_w;
        default: ;
      endcase
    end
    if (cmd_i.emit) begin
      ps_out_q   <= ps_q;
      sink_out_q <= sat_add(sink_in_q, ps_q);
      fb_out_q   <= fb_q;
    end
  end

  assign stat_o.busy    = busy_w;
  assign stat_o.done    = done_w;
  assign stat_o.case_a  = water_out_q <= 64'sd0;
  assign stat_o.dw_neg  = dwater_q[63];
  assign stat_o.case_c  = (dwater_q > 64'sd0) && (water_in_q > 64'sd0);
  assign stat_o.approx  = approx_w;
  assign stat_o.dm_zero = dmatter_q == 64'sd0;

  assign pore_sink_o       = ps_out_q;
  assign matrix_sink_out_o = sink_out_q;
  assign flux_below_o      = fb_out_q;

endmodule
`default_nettype wire

// File: src/msls_ctrl.sv
`default_nettype none
module msls_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire msls_pkg::stat_t stat_i,
  output msls_pkg::cmd_t       cmd_o
);
  import msls_pkg::*;

  state_e state_q, state_d;
  logic   started_q, started_d, out_valid_q, out_valid_d;
  op_e    op_w;
  state_e next_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Map each step state to its unit operation and successor
  always_comb begin
    unique case (state_q)
      ST_FC:   begin op_w = OP_FC;   next_w = ST_TS;    end
      ST_TS:   begin op_w = OP_TS;   next_w = ST_AV;    end
      ST_AV:   begin op_w = OP_AV;   next_w = ST_CHECK; end
      ST_TOL1: begin op_w = OP_TOL1; next_w = stat_i.approx ? ST_MF : ST_FRAC; end
      ST_FRAC: begin op_w = OP_FRAC; next_w = ST_MF;    end
      ST_MF:   begin op_w = OP_MF;   next_w = ST_CHECK; end
      ST_TOL2: begin op_w = OP_TOL2; next_w = ST_DZ;    end
      ST_DZ:   begin op_w = OP_DZ;   next_w = ST_DT;    end
      ST_DT:   begin op_w = OP_DT;   next_w = ST_OUT;   end
      default: begin op_w = OP_NONE; next_w = ST_IDLE;  end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    started_d   = started_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.sel   = op_w;
    cmd_o.load  = in_valid_i && (state_q == ST_IDLE);
    in_stall_o  = state_q != ST_IDLE;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CLASS;
        end
      end
      ST_CLASS: begin
        cmd_o.cls = 1'b1;
        if (stat_i.case_a) begin
          state_d = ST_CHECK;
        end else if (stat_i.dw_neg) begin
          state_d = ST_FC;
        end else if (stat_i.case_c) begin
          state_d = ST_TOL1;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.dm_zero) begin
          cmd_o.pass = 1'b1;
          state_d    = ST_OUT;
        end else begin
          state_d = ST_TOL2;
        end
      end
      ST_OUT: begin
        // Hand over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        // Start the unit, then capture its result
        if (!started_q) begin
          cmd_o.go  = 1'b1;
          started_d = 1'b1;
        end else if (stat_i.done) begin
          cmd_o.cap = 1'b1;
          started_d = 1'b0;
          state_d   = next_w;
        end
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_go_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.go |-> !stat_i.busy)
    else $error("unit started while busy");
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_o)
    else $error("result lost after emit");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !(out_valid_q && out_stall_i))
    else $error("stalled result overwritten");
  a_load_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_CLASS))
    else $error("accepted beat not processed");
  a_cap_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cap |-> (stat_i.done && !cmd_o.go))
    else $error("capture without unit result");

endmodule
`default_nettype wire

// File: src/macropore_solute_layer_step.sv
// Macropore solute step: one soil layer per input beat, top to bottom.
// Input channel: in_valid_i / in_stall_o with the layer fields; a beat with
// first_layer_i set takes surface_flux_i as the flux from above, otherwise
// the flux below of the previous result is used.
// Output channel: out_valid_o / out_stall_i with pore sink, updated matrix
// sink and flux below, one result beat per input beat.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 time step, 1 equality tolerance); the user writes only while the block
// is idle, which the block itself does not enforce. When matter moves,
// each of up to six multiply or divide steps runs through one shared
// bit-serial unit, with a start and a capture around each. One layer is in
// work at a time; the next beat is taken once the result is handed over.
// A finished result sits in the output register; a new beat is accepted
// while it waits, and a stalled output only holds the block at its last step.
// Reset clears the carried flux and loads the default configuration.
`default_nettype none
module macropore_solute_layer_step #(
  parameter int FRACTION_BITS = 48
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [62:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               first_layer_i,
  input  wire logic signed [63:0] surface_flux_i,
  input  wire logic [62:0]        layer_thickness_i,
  input  wire logic signed [63:0] pore_flux_top_i,
  input  wire logic signed [63:0] pore_flux_bottom_i,
  input  wire logic [62:0]        concentration_i,
  input  wire logic [62:0]        matrix_matter_i,
  input  wire logic signed [63:0] matrix_sink_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [63:0]      pore_sink_o,
  output logic signed [63:0]      matrix_sink_out_o,
  output logic signed [63:0]      flux_below_o
);
  import msls_pkg::*;

  cmd_t  cmd_w;
  stat_t stat_w;

  msls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat_w),
    .cmd_o       (cmd_w)
  );

  msls_dp #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd_w),
    .stat_o             (stat_w),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .first_layer_i      (first_layer_i),
    .surface_flux_i     (surface_flux_i),
    .layer_thickness_i  (layer_thickness_i),
    .pore_flux_top_i    (pore_flux_top_i),
    .pore_flux_bottom_i (pore_flux_bottom_i),
    .concentration_i    (concentration_i),
    .matrix_matter_i    (matrix_matter_i),
    .matrix_sink_in_i   (matrix_sink_in_i),
    .pore_sink_o        (pore_sink_o),
    .matrix_sink_out_o  (matrix_sink_out_o),
    .flux_below_o       (flux_below_o)
  );

endmodule
`default_nettype wire

// File: sim/macropore_solute_layer_step_test.sv
`timescale 1ns / 1ps
`default_nettype none
module macropore_solute_layer_step_test;
  import msls_pkg::*;

  localparam logic signed [63:0] Q_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] Q_MIN = {1'b1, 63'd0};
  localparam logic [63:0] Q_ONE = 64'd1 << 48;
  localparam logic [62:0] TS_RESET = 63'd281474976710656;
  localparam logic [48:0] TOL_RESET = 49'd28147497671;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 450;

  typedef struct {
    bit                 first;
    logic signed [63:0] surface;
    logic [62:0]        thick;
    logic signed [63:0] q_top;
    logic signed [63:0] q_bot;
    logic [62:0]        conc;
    logic [62:0]        matter;
    logic signed [63:0] sink;
  } layer_t;

  typedef struct {
    logic signed [63:0] pore_sink;
    logic signed [63:0] matrix_sink;
    logic signed [63:0] flux_below;
  } sinks_t;

  // How solute left the pore in a layer
  typedef enum int {ROUTE_PASS, ROUTE_HOLD, ROUTE_DRAW, ROUTE_SHARE} route_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = REG_TIME_STEP;
  logic [62:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic first_layer_i = 1'b0;
  logic signed [63:0] surface_flux_i = '0;
  logic [62:0] layer_thickness_i = 63'd1;
  logic signed [63:0] pore_flux_top_i = '0;
  logic signed [63:0] pore_flux_bottom_i = '0;
  logic [62:0] concentration_i = '0;
  logic [62:0] matrix_matter_i = '0;
  logic signed [63:0] matrix_sink_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [63:0] pore_sink_o;
  logic signed [63:0] matrix_sink_out_o;
  logic signed [63:0] flux_below_o;

  macropore_solute_layer_step i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .first_layer_i, .surface_flux_i,
    .layer_thickness_i, .pore_flux_top_i, .pore_flux_bottom_i,
    .concentration_i, .matrix_matter_i, .matrix_sink_in_i,
    .out_valid_o, .out_stall_i, .pore_sink_o, .matrix_sink_out_o, .flux_below_o
  );

  always #5 clk_i = ~clk_i;

  layer_t layer_q[$];
  sinks_t sinks_q[$];
  logic [62:0] step_len = TS_RESET;
  logic [48:0] tol = TOL_RESET;
  logic signed [63:0] carry_flux = '0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_go = 0;
  bit hold_seen = 0;
  int hold_left = 0;
  bit in_took = 0;
  int mismatches = 0;
  int checked = 0;
  int layers_sent = 0;
  int tops_sent = 0;
  int route_cnt[4] = '{0, 0, 0, 0};
  int quiet = 0;

  // Saturating fixed-point helpers
  function automatic logic signed [63:0] clip(input logic signed [64:0] s);
    if (s > 65'sd9223372036854775807) return Q_MAX;
    if (s < -65'sd9223372036854775808) return Q_MIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] s_add(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] x, y;
    x = a;
    y = b;
    return clip(x + y);
  endfunction

  function automatic logic signed [63:0] s_sub(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] x, y;
    x = a;
    y = b;
    return clip(x - y);
  endfunction

  function automatic logic signed [63:0] s_neg(input logic signed [63:0] a);
    return (a == Q_MIN) ? Q_MAX : -a;
  endfunction

  function automatic logic [63:0] u_abs(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] signed_of(input bit neg, input logic [127:0] m);
    if (neg) return (m >= (128'd1 << 63)) ? Q_MIN : -$signed(m[63:0]);
    return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? Q_MAX : $signed(m[63:0]);
  endfunction

  function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                               input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, u_abs(a)} * {64'd0, b};
    return signed_of(a[63], p >> 48);
  endfunction

  function automatic logic signed [63:0] q_div(input logic signed [63:0] a,
                                               input logic [63:0] b);
    logic [127:0] n;
    logic [127:0] d;
    d = (b == 0) ? 128'd1 : {64'd0, b};
    n = {64'd0, u_abs(a)} << 48;
    return signed_of(a[63], n / d);
  endfunction

  function automatic bit near(input logic signed [63:0] a, input logic signed [63:0] b);
    logic signed [64:0] d;
    logic [127:0] lhs, rhs;
    if (b == 0) return a == 0;
    d = 65'(a) - 65'(b);
    lhs = {64'd0, (d[64] ? 64'(-d) : 64'(d))} << 48;
    rhs = {79'd0, tol} * {64'd0, u_abs(b)};
    return lhs < rhs;
  endfunction

  // Work out the sinks for one layer and advance the carried flux
  function automatic sinks_t route_layer(input layer_t l);
    logic signed [63:0] f_in, w_in, w_out, dw, m_in, dm, from_c, avail, frac;
    sinks_t r;
    f_in = l.first ? l.surface : carry_flux;
    w_in = s_neg(l.q_top);
    w_out = s_neg(l.q_bot);
    dw = s_sub(w_in, w_out);
    m_in = s_neg(f_in);
    dm = 0;
    if (w_out <= 0) begin
      dm = s_neg(m_in);
    end else if (dw < 0) begin
      from_c = q_mul($signed({1'b0, l.conc}), u_abs(dw));
      avail = s_add($signed({1'b0, l.matter}), q_mul(l.sink, {1'b0, step_len}));
      avail = s_sub(q_mul(avail, {1'b0, l.thick}), 64'sd1);
      dm = (from_c < avail) ? from_c : avail;
      if (dm < 0) dm = 0;
    end else if (dw > 0 && w_in > 0) begin
      frac = near(dw, w_in) ? $signed(Q_ONE) : q_div(dw, w_in);
      if (frac < 0) frac = 0;
      if (frac > $signed(Q_ONE)) frac = $signed(Q_ONE);
      dm = s_neg(q_mul(m_in, frac));
    end
    if (dm == 0) begin
      r.flux_below = f_in;
      r.pore_sink = 0;
      route_cnt[ROUTE_PASS]++;
    end else if (near(m_in, s_neg(dm))) begin
      r.flux_below = 0;
      r.pore_sink = q_div(q_div(m_in, {1'b0, l.thick}), {1'b0, step_len});
      route_cnt[ROUTE_HOLD]++;
    end else begin
      r.flux_below = s_neg(s_add(m_in, dm));
      r.pore_sink = q_div(q_div(s_neg(dm), {1'b0, l.thick}), {1'b0, step_len});
      route_cnt[(w_out > 0 && dw < 0) ? ROUTE_DRAW : ROUTE_SHARE]++;
    end
    r.matrix_sink = s_add(l.sink, r.pore_sink);
    carry_flux = r.flux_below;
    return r;
  endfunction

  // Random values: mostly moderate magnitudes, sometimes zero or an extreme
  function automatic logic signed [63:0] rnd_signed();
    logic [63:0] v;
    int pick;
    pick = $urandom_range(0, 11);
    v = {$urandom, $urandom};
    if (pick == 0) return 0;
    if (pick == 1) return Q_MAX;
    if (pick == 2) return Q_MIN;
    if (pick == 3) return $signed(v);
    v = v >> $urandom_range(8, 44);
    return $urandom_range(0, 1) ? -$signed(v) : $signed(v);
  endfunction

  function automatic logic [62:0] rnd_unsigned(input bit nonzero);
    logic [62:0] v;
    int pick;
    pick = $urandom_range(0, 11);
    v = 63'({$urandom, $urandom});
    if (pick == 0) v = 0;
    else if (pick == 1) v = '1;
    else if (pick > 2) v = v >> $urandom_range(8, 44);
    return (nonzero && v == 0) ? 63'd1 : v;
  endfunction

  function automatic void add_layer(input bit first, input logic signed [63:0] surface,
                                    input logic [62:0] thick,
                                    input logic signed [63:0] q_top,
                                    input logic signed [63:0] q_bot,
                                    input logic [62:0] conc, input logic [62:0] matter,
                                    input logic signed [63:0] sink);
    layer_t l;
    l.first = first;
    l.surface = surface;
    l.thick = thick;
    l.q_top = q_top;
    l.q_bot = q_bot;
    l.conc = conc;
    l.matter = matter;
    l.sink = sink;
    layer_q.push_back(l);
  endfunction

  // Profiles of a few layers, top first, with random content
  task automatic add_profiles(input int count);
    logic signed [63:0] top;
    int depth;
    while (count > 0) begin
      depth = $urandom_range(1, 8);
      top = rnd_signed();
      for (int k = 0; k < depth && count > 0; k++) begin
        add_layer(k == 0 || $urandom_range(0, 19) == 0, rnd_signed(),
                  rnd_unsigned(1), top,
                  $urandom_range(0, 2) ? s_add(top, rnd_signed() >>> 4) : rnd_signed(),
                  rnd_unsigned(0), rnd_unsigned(0), rnd_signed());
        top = layer_q[$].q_bot;
        count--;
      end
    end
  endtask

  task automatic reg_write(input logic idx, input logic [62:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    if (idx == REG_TIME_STEP) step_len = data;
    else tol = data[48:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (layer_q.size() != 0 || in_valid_i || sinks_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Feed layers: hold the beat while stalled, idle at random
  always @(negedge clk_i) begin
    if (!in_valid_i || in_took) begin
      if (rst_ni && layer_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        first_layer_i <= layer_q[0].first;
        surface_flux_i <= layer_q[0].surface;
        layer_thickness_i <= layer_q[0].thick;
        pore_flux_top_i <= layer_q[0].q_top;
        pore_flux_bottom_i <= layer_q[0].q_bot;
        concentration_i <= layer_q[0].conc;
        matrix_matter_i <= layer_q[0].matter;
        matrix_sink_in_i <= layer_q[0].sink;
        void'(layer_q.pop_front());
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the result side at random, or for one long stretch on request
  always @(negedge clk_i) begin
    if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Predict on each accepted layer, check each accepted result
  always @(posedge clk_i) begin
    sinks_t want;
    bit fire_in, fire_out;
    fire_in = rst_ni && in_valid_i && !in_stall_o;
    fire_out = rst_ni && out_valid_o && !out_stall_i;
    in_took <= fire_in;
    if (fire_in) begin
      layer_t l;
      l.first = first_layer_i;
      l.surface = surface_flux_i;
      l.thick = layer_thickness_i;
      l.q_top = pore_flux_top_i;
      l.q_bot = pore_flux_bottom_i;
      l.conc = concentration_i;
      l.matter = matrix_matter_i;
      l.sink = matrix_sink_in_i;
      sinks_q.push_back(route_layer(l));
      layers_sent++;
      if (l.first) tops_sent++;
    end
    if (fire_out) begin
      if (sinks_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        want = sinks_q.pop_front();
        checked++;
        if (pore_sink_o !== want.pore_sink || matrix_sink_out_o !== want.matrix_sink ||
            flux_below_o !== want.flux_below) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: pore_sink exp %0d got %0d", $realtime,
                     want.pore_sink, pore_sink_o);
            $display("  matrix_sink exp %0d got %0d, flux_below exp %0d got %0d",
                     want.matrix_sink, matrix_sink_out_o, want.flux_below, flux_below_o);
          end
        end
      end
    end
    // Watchdog on progress: count while a beat waits or results are owed
    if (fire_in || fire_out || (sinks_q.size() == 0 && !in_valid_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed layers under the reset configuration
    send_idle_pct = 8;
    recv_idle_pct = 65;
    add_layer(1, -64'sd281474976710656, 63'd281474976710656, -64'sd281474976710656,
              64'sd0, 63'd1000, 63'd1000, 64'sd0);
    add_layer(0, 64'sd0, 63'd1, -64'sd281474976710656, -64'sd1, '0, '0, 64'sd0);
    add_layer(1, -64'sd281474976710656, 63'd281474976710656, -64'sd281474976710656,
              -64'sd1, 63'd5, 63'd5, 64'sd0);
    add_layer(1, -64'sd1000000, 63'd281474976710656, -64'sd281474976710656,
              -64'sd140737488355328, '0, '0, 64'sd0);
    add_layer(1, -64'sd1000000, 63'd281474976710656, -64'sd281474976710656,
              -64'sd562949953421312, 63'd281474976710656, 63'd281474976710656, 64'sd0);
    add_layer(0, 64'sd0, '1, -64'sd1, Q_MIN, '1, '1, Q_MAX);
    add_layer(0, 64'sd0, '1, Q_MAX, Q_MIN, '1, '0, Q_MIN);
    add_layer(1, Q_MIN, 63'd1, Q_MIN, Q_MIN, '1, '1, Q_MAX);
    add_layer(1, Q_MAX, 63'd1, Q_MIN, -64'sd5, '0, '1, Q_MIN);
    add_layer(0, Q_MIN, '1, Q_MAX, Q_MAX, '0, '0, Q_MAX);
    add_layer(1, Q_MIN, 63'd281474976710656, -64'sd3, -64'sd2, '1, '0, Q_MIN);
    add_layer(0, Q_MAX, 63'd2, -64'sd2, -64'sd3, '0, '0, Q_MIN);
    add_layer(1, -64'sd1, 63'd1, -64'sd1, -64'sd2, 63'd1, 63'd1, -64'sd1);
    add_profiles(110);
    drain();

    // Extreme step, exact comparisons
    reg_write(REG_TIME_STEP, '1);
    reg_write(REG_EQUAL_TOL, '0);
    add_profiles(120);
    drain();

    // Other way round: sender idles more than the receiver
    send_idle_pct = 65;
    recv_idle_pct = 8;
    reg_write(REG_TIME_STEP, 63'd1);
    reg_write(REG_EQUAL_TOL, 63'd281474976710656);
    add_profiles(130);
    drain();

    reg_write(REG_TIME_STEP, 63'(64'd1 << $urandom_range(40, 54)) | 63'($urandom));
    reg_write(REG_EQUAL_TOL, 63'($urandom) << $urandom_range(0, 17));
    add_profiles(140);
    drain();

    // No idling; one long hold on results while layers keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    reg_write(REG_TIME_STEP, TS_RESET);
    reg_write(REG_EQUAL_TOL, 63'(TOL_RESET));
    add_profiles(180);
    hold_go = 1;
    drain();

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (sinks_q.size() != 0) mismatches++;
    $display("Covered %0d layers (%0d top layers), %0d results checked over five settings.",
             layers_sent, tops_sent, checked);
    $display("Routes: pass %0d, held %0d, drawn from matrix %0d, shared %0d.",
             route_cnt[ROUTE_PASS], route_cnt[ROUTE_HOLD], route_cnt[ROUTE_DRAW],
             route_cnt[ROUTE_SHARE]);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
src/msls_pkg.sv
src/msls_mdu.sv
src/msls_dp.sv
src/msls_ctrl.sv
src/macropore_solute_layer_step.sv
sim/macropore_solute_layer_step_test.sv
